@@ rtl/mhpq_pkg.sv @@
// Package for the max-heap priority queue.
// Holds the command and status codes and the default capacity; no dependencies.
`default_nettype none

package mhpq_pkg;

  localparam int DefaultCapacity = 64;
  localparam int ValueW          = 32;
  localparam int StatusW         = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

@@ rtl/mhpq_ram.sv @@
// Heap entry store: one synchronous write port, two synchronous read ports.
// Read data is registered and appears in the cycle after the address. Uses mhpq_pkg.
`default_nettype none

module mhpq_ram import mhpq_pkg::*; #(
  parameter  int Depth = DefaultCapacity,
  localparam int AW    = $clog2(Depth)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [ValueW-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_a_i,
  input  wire logic [AW-1:0]     raddr_b_i,
  output logic      [ValueW-1:0] rdata_a_o,
  output logic      [ValueW-1:0] rdata_b_o
);

  logic [ValueW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

@@ rtl/max_heap_priority_queue.sv @@
// Top level of the binary max-heap priority queue of signed 32-bit values.
// Depends on mhpq_pkg and mhpq_ram.
`default_nettype none

// A command transaction either inserts value_in_i (command 0) or removes the
// maximum (command 1); every command returns one result transaction with the
// removed value (zero unless a delete succeeded), a status (ok, empty, full)
// and the count after the command. Entries live in a two-read, one-write RAM
// and the heap is kept with a hole: the moving value waits in a register and
// only the displaced entries are written back. The block takes one command at
// a time. An insert reads the parent of the new slot and, per level climbed,
// writes the parent into the hole and reads the next parent; a delete reads
// the root and the last entry, then per level sunk reads both children and
// lifts the larger. A failed command goes straight to the output. No clearing
// pass runs after reset: only entries below the count are ever used.
module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter  int Capacity = DefaultCapacity,
  localparam int AW       = $clog2(Capacity),
  localparam int CntW     = $clog2(Capacity + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      command_i,
  input  wire logic signed [ValueW-1:0]  value_in_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed      [ValueW-1:0]  value_out_o,
  output logic             [StatusW-1:0] status_o,
  output logic             [CntW-1:0]    count_out_o
);

  // Child indices reach 2 * Capacity, so give them two bits beyond an address.
  localparam int IW = AW + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;  // parent data arriving, climb or settle
  localparam logic [2:0] S_DN0  = 3'd2;  // root and last entry arriving
  localparam logic [2:0] S_DN   = 3'd3;  // both children arriving, sink or settle
  localparam logic [2:0] S_PUT  = 3'd4;  // drop the held value into the hole
  localparam logic [2:0] S_OUT  = 3'd5;  // move the result to the output register

  logic [2:0]               state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [AW-1:0]            pos_q, pos_d;     // hole position
  logic [AW-1:0]            par_q, par_d;     // parent being read during climb
  logic signed [ValueW-1:0] val_q, val_d;     // value that moves through the heap
  logic signed [ValueW-1:0] res_val_q, res_val_d;
  logic [StatusW-1:0]       res_st_q, res_st_d;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [ValueW-1:0]        mem_wdata;
  logic signed [ValueW-1:0] rd_a, rd_b;
  logic [ValueW-1:0]        rd_a_raw, rd_b_raw;

  logic                     out_load;
  logic [CntW-1:0]          cnt_m1;
  logic [IW-1:0]            n_w, l_w, r_w, big_w, nl_w;
  logic signed [ValueW-1:0] big_val;

  mhpq_ram #(
    .Depth (Capacity)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (rd_a_raw),
    .rdata_b_o (rd_b_raw)
  );

  assign rd_a = $signed(rd_a_raw);
  assign rd_b = $signed(rd_b_raw);

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_valid_o || out_ready_i);
  assign cnt_m1     = count_q - CntW'(1);

  // Sift-down indices, relative to the current hole and the shrunken count.
  assign n_w     = IW'(count_q);
  assign l_w     = {1'b0, pos_q, 1'b1};
  assign r_w     = l_w + IW'(1);
  assign big_w   = ((r_w < n_w) && (rd_b > rd_a)) ? r_w : l_w;
  assign big_val = ((r_w < n_w) && (rd_b > rd_a)) ? rd_b : rd_a;
  assign nl_w    = {1'b0, big_w[AW-1:0], 1'b1};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    par_d       = par_q;
    val_d       = val_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = val_q;
    mem_raddr_a = '0;
    mem_raddr_b = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_val_d = '0;
          res_st_d  = ST_OK;
          val_d     = value_in_i;
          if (command_i == CMD_INSERT) begin
            if (count_q == CntW'(Capacity)) begin
              res_st_d = ST_FULL;
              state_d  = S_OUT;
            end else begin
              count_d     = count_q + CntW'(1);
              pos_d       = count_q[AW-1:0];
              par_d       = AW'(cnt_m1 >> 1);
              mem_raddr_a = AW'(cnt_m1 >> 1);
              // First entry goes straight to the root.
              state_d     = (count_q == '0) ? S_PUT : S_UP;
            end
          end else begin
            if (count_q == '0) begin
              res_st_d = ST_EMPTY;
              state_d  = S_OUT;
            end else begin
              count_d     = cnt_m1;
              pos_d       = '0;
              mem_raddr_a = '0;
              mem_raddr_b = cnt_m1[AW-1:0];
              state_d     = S_DN0;
            end
          end
        end
      end

      S_UP: begin
        if (val_q > rd_a) begin
          // Pull the parent down into the hole and climb.
          mem_we      = 1'b1;
          mem_waddr   = pos_q;
          mem_wdata   = rd_a;
          pos_d       = par_q;
          par_d       = AW'((par_q - AW'(1)) >> 1);
          mem_raddr_a = AW'((par_q - AW'(1)) >> 1);
          state_d     = (par_q == '0) ? S_PUT : S_UP;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = val_q;
          state_d   = S_OUT;
        end
      end

      S_DN0: begin
        res_val_d   = rd_a;
        val_d       = rd_b;
        mem_raddr_a = AW'(1);
        mem_raddr_b = AW'(2);
        state_d     = (IW'(1) >= n_w) ? S_PUT : S_DN;
      end

      S_DN: begin
        if (big_val > val_q) begin
          // Lift the larger child into the hole and sink.
          mem_we      = 1'b1;
          mem_waddr   = pos_q;
          mem_wdata   = big_val;
          pos_d       = big_w[AW-1:0];
          mem_raddr_a = nl_w[AW-1:0];
          mem_raddr_b = nl_w[AW-1:0] + AW'(1);
          state_d     = (nl_w >= n_w) ? S_PUT : S_DN;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = val_q;
          state_d   = S_OUT;
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
        state_d   = S_OUT;
      end

      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    par_q     <= par_d;
    val_q     <= val_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      value_out_o <= res_val_q;
      status_o    <= res_st_q;
      count_out_o <= count_q;
    end
  end

  // Count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  // An accepted command always leaves the idle state.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("command accepted but block stayed idle");

  // The RAM is written only while a command is being worked on.
  a_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q != S_IDLE) && (state_q != S_OUT) && (state_q != S_DN0)))
    else $error("heap write outside a sift");

  // An empty status always reports an empty heap and no value.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY)) |-> ((count_out_o == '0) && (value_out_o == '0)))
    else $error("empty status with nonzero count or value");

endmodule

`default_nettype wire
